FILE: hw/rtl/ntt_pkg.sv
// shared types, constants, modular arithmetic and elaboration-time helpers for the ntt polynomial multiplier
// no dependencies
package ntt_pkg;

  localparam int unsigned COEF_W    = 30;
  localparam int unsigned MODULUS   = 998244353;
  localparam int unsigned ROOT      = 3;
  localparam int unsigned MAX_TERMS_DEF = 32;
  localparam int unsigned POINTS_DEF    = 64;
  // 998244352 = 119 * 2^23, so roots of unity exist up to 2^23 points
  localparam int unsigned ROOT_LG_MAX = 23;

  typedef logic [COEF_W-1:0] coef_t;

  typedef enum logic [1:0] {
    OP_LOAD_A = 2'd0,
    OP_LOAD_B = 2'd1,
    OP_MULT   = 2'd2
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_MULT
  } cmd_e;

  typedef struct packed {
    logic [1:0] opcode;
    coef_t      coefficient;
  } in_item_t;

  typedef struct packed {
    coef_t product_coefficient;
    logic  last;
    logic  dropped;
    logic  empty_res;
  } out_item_t;

  typedef struct packed {
    cmd_e  kind;
    coef_t coef;
  } cmd_t;

  localparam logic [COEF_W:0] MOD_EXT = (COEF_W+1)'(MODULUS);

  function automatic coef_t mod_add(coef_t a, coef_t b);
    logic [COEF_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= MOD_EXT) s = s - MOD_EXT;
    return s[COEF_W-1:0];
  endfunction

  function automatic coef_t mod_sub(coef_t a, coef_t b);
    logic [COEF_W:0] s;
    if (a >= b) s = {1'b0, a} - {1'b0, b};
    else        s = {1'b0, a} + MOD_EXT - {1'b0, b};
    return s[COEF_W-1:0];
  endfunction

  // elaboration-time only
  function automatic longint unsigned mod_mul_c(longint unsigned a, longint unsigned b);
    return (a * b) % MODULUS;
  endfunction

  function automatic longint unsigned mod_pow_c(longint unsigned base, longint unsigned e);
    longint unsigned acc;
    longint unsigned bb;
    longint unsigned ee;
    acc = 1;
    bb  = base % MODULUS;
    ee  = e;
    while (ee != 0) begin
      if (ee[0]) acc = mod_mul_c(acc, bb);
      bb = mod_mul_c(bb, bb);
      ee = ee >> 1;
    end
    return acc;
  endfunction

  // entry s holds the primitive 2^s-th root of unity
  function automatic logic [ROOT_LG_MAX:0][COEF_W-1:0] root_table();
    logic [ROOT_LG_MAX:0][COEF_W-1:0] t;
    for (int s = 0; s <= ROOT_LG_MAX; s++) begin
      t[s] = COEF_W'(mod_pow_c(ROOT, (MODULUS - 1) >> s));
    end
    return t;
  endfunction

endpackage

FILE: hw/rtl/ntt_front.sv
// front end: takes input requests, reduces the coefficient, classifies the opcode
// and holds commands in a two-entry queue; depends on ntt_pkg
module ntt_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  ntt_pkg::in_item_t in_item_i,
  output logic             full_o,
  output logic             cmd_valid_o,
  output ntt_pkg::cmd_t    cmd_o,
  input  logic             cmd_ready_i
);
  import ntt_pkg::*;

  cmd_t       q_mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  coef_t reduced;
  cmd_t  cmd_new;
  logic  keep;
  logic  do_wr, do_rd;

  always_comb begin
    reduced = in_item_i.coefficient;
    if (in_item_i.coefficient >= COEF_W'(MODULUS)) begin
      reduced = in_item_i.coefficient - COEF_W'(MODULUS);
    end
    keep    = 1'b1;
    cmd_new = '{kind: CMD_LOAD_A, coef: reduced};
    case (opcode_e'(in_item_i.opcode))
      OP_LOAD_A: cmd_new.kind = CMD_LOAD_A;
      OP_LOAD_B: cmd_new.kind = CMD_LOAD_B;
      OP_MULT:   cmd_new.kind = CMD_MULT;
      default:   keep = 1'b0;  // unused opcode is taken and dropped
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = q_mem_q[rd_ptr_q];
  assign do_wr       = push_i && !full_o && keep;
  assign do_rd       = cmd_valid_o && cmd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_wr;
    rd_ptr_d = rd_ptr_q ^ do_rd;
    cnt_d    = cnt_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) q_mem_q[wr_ptr_q] <= cmd_new;
  end

endmodule

FILE: hw/rtl/ntt_modmul.sv
// bit-serial modular multiplier, one bit of b per cycle, msb first
// depends on ntt_pkg
module ntt_modmul (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  ntt_pkg::coef_t a_i,
  input  ntt_pkg::coef_t b_i,
  output logic          done_o,
  output ntt_pkg::coef_t p_o
);
  import ntt_pkg::*;

  localparam int unsigned CW = $clog2(COEF_W + 1);

  coef_t           a_q, b_q, acc_q;
  logic [CW-1:0]   cnt_q;
  logic            busy_q, done_q;
  logic [COEF_W:0] dbl, sum;

  always_comb begin
    dbl = {acc_q, 1'b0};
    if (dbl >= MOD_EXT) dbl = dbl - MOD_EXT;
    sum = dbl + (b_q[COEF_W-1] ? {1'b0, a_q} : '0);
    if (sum >= MOD_EXT) sum = sum - MOD_EXT;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      a_q    <= '0;
      b_q    <= '0;
      acc_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(COEF_W);
        a_q    <= a_i;
        b_q    <= b_i;
        acc_q  <= '0;
      end else if (busy_q) begin
        acc_q <= sum[COEF_W-1:0];
        b_q   <= {b_q[COEF_W-2:0], 1'b0};
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign p_o    = acc_q;

endmodule

FILE: hw/rtl/ntt_engine.sv
// back end: coefficient stores, work memories and the transform sequencer with one
// butterfly datapath built on two modular multipliers; depends on ntt_pkg, ntt_modmul
module ntt_engine #(
  parameter int unsigned MAX_TERMS        = ntt_pkg::MAX_TERMS_DEF,
  parameter int unsigned TRANSFORM_POINTS = ntt_pkg::POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cmd_valid_i,
  input  ntt_pkg::cmd_t      cmd_i,
  output logic               cmd_ready_o,
  output logic               out_valid_o,
  output ntt_pkg::out_item_t out_item_o,
  input  logic               pop_i
);
  import ntt_pkg::*;

  localparam int unsigned AW   = $clog2(TRANSFORM_POINTS);
  localparam int unsigned SAW  = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNTW = $clog2(MAX_TERMS + 1);
  localparam int unsigned IW   = $clog2(2 * MAX_TERMS + TRANSFORM_POINTS) + 1;
  localparam int unsigned SW   = $clog2(AW + 1);
  localparam logic [CNTW-1:0] CNT_MAX = CNTW'(MAX_TERMS);
  localparam logic [IW-1:0]   IDX_NM1 = IW'(TRANSFORM_POINTS - 1);
  localparam logic [IW-1:0]   IDX_HM1 = IW'(TRANSFORM_POINTS / 2 - 1);
  localparam logic [SW-1:0]   LG_LAST = SW'(AW);
  localparam logic [ROOT_LG_MAX:0][COEF_W-1:0] ROOTS = root_table();
  localparam coef_t INV_N =
    COEF_W'(mod_pow_c(TRANSFORM_POINTS % MODULUS, MODULUS - 2));

  typedef enum logic [4:0] {
    S_IDLE, S_EMPTY, S_CLR, S_FRD, S_FWR,
    S_BR_RD1, S_BR_RD2, S_BR_W1, S_BR_W2,
    S_BF_RD1, S_BF_RD2, S_BF_MUL, S_BF_WAIT, S_BF_W2,
    S_PW_RD, S_PW_MUL, S_PW_WAIT,
    S_EM_RD, S_EM_MUL, S_EM_WAIT, S_EM_OUT
  } state_e;

  typedef enum logic [1:0] {
    PASS_A, PASS_B, PASS_INV
  } pass_e;

  // memories
  coef_t store_a [MAX_TERMS];
  coef_t store_b [MAX_TERMS];
  coef_t work_a  [TRANSFORM_POINTS];
  coef_t work_b  [TRANSFORM_POINTS];
  coef_t sa_rd_q, sb_rd_q, wa_rd_q, wb_rd_q;

  state_e          state_q;
  pass_e           pass_q;
  logic [IW-1:0]   idx_q;
  logic [SW-1:0]   lg_q;
  logic [CNTW-1:0] cnt_a_q, cnt_b_q;
  logic            ovf_q;
  coef_t           tmp_q, t_q, g_q, res_q;
  logic            out_valid_q;
  out_item_t       out_q;

  // memory port controls
  logic [AW-1:0]  raddr, waddr;
  logic           wa_we, wb_we, sa_we, sb_we;
  coef_t          wa_wd, wb_wd;
  logic [SAW-1:0] s_raddr, s_waddr;

  // multipliers
  logic  m_start, m0_done, m1_done;
  coef_t m0_a, m0_b, m1_a, m0_p, m1_p;

  // index helpers
  logic [AW-1:0]   ai, br_j, lo_mask, half, kk, kh;
  logic            j_zero, sel_b, slot_free, out_load;
  coef_t           rd_x, g_op, step;
  logic [IW-1:0]   size, fmax;

  function automatic logic [AW-1:0] bit_rev(logic [AW-1:0] v);
    logic [AW-1:0] r;
    for (int b = 0; b < AW; b++) r[b] = v[AW-1-b];
    return r;
  endfunction

  always_comb begin
    ai      = idx_q[AW-1:0];
    br_j    = bit_rev(ai);
    half    = AW'(1) << (lg_q - SW'(1));
    lo_mask = half - AW'(1);
    kk      = ((ai & ~lo_mask) << 1) | (ai & lo_mask);
    kh      = kk | half;
    j_zero  = ((ai & lo_mask) == '0);
    sel_b   = (pass_q == PASS_B);
    rd_x    = sel_b ? wb_rd_q : wa_rd_q;
    g_op    = j_zero ? COEF_W'(1) : g_q;
    step    = ROOTS[5'(lg_q)];
    size    = IW'(cnt_a_q) + IW'(cnt_b_q) - IW'(1);
    fmax    = (cnt_a_q > cnt_b_q) ? IW'(cnt_a_q) : IW'(cnt_b_q);
    slot_free = !out_valid_q || pop_i;
    out_load  = ((state_q == S_EMPTY) || (state_q == S_EM_OUT)) && slot_free;
  end

  // datapath steering per state
  always_comb begin
    raddr   = ai;
    waddr   = ai;
    wa_we   = 1'b0;
    wb_we   = 1'b0;
    wa_wd   = '0;
    wb_wd   = '0;
    s_raddr = idx_q[SAW-1:0];
    s_waddr = '0;
    sa_we   = 1'b0;
    sb_we   = 1'b0;
    m_start = 1'b0;
    m0_a    = g_op;
    m0_b    = rd_x;
    m1_a    = g_op;
    case (state_q)
      S_IDLE: begin
        s_waddr = (cmd_i.kind == CMD_LOAD_A) ? cnt_a_q[SAW-1:0] : cnt_b_q[SAW-1:0];
        if (cmd_valid_i && cmd_i.kind == CMD_LOAD_A && cnt_a_q < CNT_MAX) sa_we = 1'b1;
        if (cmd_valid_i && cmd_i.kind == CMD_LOAD_B && cnt_b_q < CNT_MAX) sb_we = 1'b1;
      end
      S_CLR: begin
        wa_we = 1'b1;
        wb_we = 1'b1;
      end
      S_FWR: begin
        wa_we = 1'b1;
        wb_we = 1'b1;
        wa_wd = (idx_q < IW'(cnt_a_q)) ? mod_add(wa_rd_q, sa_rd_q) : wa_rd_q;
        wb_wd = (idx_q < IW'(cnt_b_q)) ? mod_add(wb_rd_q, sb_rd_q) : wb_rd_q;
      end
      S_BR_RD2: raddr = br_j;
      S_BR_W1: begin
        wa_we = !sel_b;
        wb_we = sel_b;
        wa_wd = rd_x;
        wb_wd = rd_x;
      end
      S_BR_W2: begin
        waddr = br_j;
        wa_we = !sel_b;
        wb_we = sel_b;
        wa_wd = tmp_q;
        wb_wd = tmp_q;
      end
      S_BF_RD1: raddr = kk;
      S_BF_RD2: raddr = kh;
      S_BF_MUL: m_start = 1'b1;
      S_BF_WAIT: begin
        waddr = kk;
        wa_we = m0_done && !sel_b;
        wb_we = m0_done && sel_b;
        wa_wd = mod_add(tmp_q, m0_p);
        wb_wd = mod_add(tmp_q, m0_p);
      end
      S_BF_W2: begin
        waddr = kh;
        wa_we = !sel_b;
        wb_we = sel_b;
        wa_wd = mod_sub(tmp_q, t_q);
        wb_wd = mod_sub(tmp_q, t_q);
      end
      S_PW_MUL: begin
        m_start = 1'b1;
        m0_a    = wa_rd_q;
        m0_b    = wb_rd_q;
      end
      S_PW_WAIT: begin
        wa_we = m0_done;
        wa_wd = m0_p;
      end
      // index reversal of the inverse transform: point i sits at -i mod n
      S_EM_RD: raddr = '0 - ai;
      S_EM_MUL: begin
        m_start = 1'b1;
        m0_a    = wa_rd_q;
        m0_b    = INV_N;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (sa_we) store_a[s_waddr] <= cmd_i.coef;
    if (sb_we) store_b[s_waddr] <= cmd_i.coef;
    sa_rd_q <= store_a[s_raddr];
    sb_rd_q <= store_b[s_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (wa_we) work_a[waddr] <= wa_wd;
    if (wb_we) work_b[waddr] <= wb_wd;
    wa_rd_q <= work_a[raddr];
    wb_rd_q <= work_b[raddr];
  end

  ntt_modmul u_mul_data (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (m_start),
    .a_i     (m0_a),
    .b_i     (m0_b),
    .done_o  (m0_done),
    .p_o     (m0_p)
  );

  // next twiddle runs alongside the butterfly product
  ntt_modmul u_mul_twiddle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (m_start),
    .a_i     (m1_a),
    .b_i     (step),
    .done_o  (m1_done),
    .p_o     (m1_p)
  );

  assign cmd_ready_o = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_A;
      idx_q       <= '0;
      lg_q        <= '0;
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ovf_q       <= 1'b0;
      tmp_q       <= '0;
      t_q         <= '0;
      g_q         <= '0;
      res_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_load)   out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            case (cmd_i.kind)
              CMD_LOAD_A: begin
                if (cnt_a_q < CNT_MAX) cnt_a_q <= cnt_a_q + 1'b1;
                else                   ovf_q   <= 1'b1;
              end
              CMD_LOAD_B: begin
                if (cnt_b_q < CNT_MAX) cnt_b_q <= cnt_b_q + 1'b1;
                else                   ovf_q   <= 1'b1;
              end
              CMD_MULT: begin
                idx_q <= '0;
                if (cnt_a_q == '0 || cnt_b_q == '0) state_q <= S_EMPTY;
                else                                state_q <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_EMPTY: begin
          if (slot_free) begin
            out_q       <= '{product_coefficient: '0, last: 1'b1,
                             dropped: ovf_q, empty_res: 1'b1};
            cnt_a_q     <= '0;
            cnt_b_q     <= '0;
            ovf_q       <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_CLR: begin
          if (idx_q == IDX_NM1) begin
            idx_q   <= '0;
            state_q <= S_FRD;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FRD: state_q <= S_FWR;
        S_FWR: begin
          if (idx_q == fmax - IW'(1)) begin
            idx_q   <= '0;
            pass_q  <= PASS_A;
            state_q <= S_BR_RD1;
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_FRD;
          end
        end
        S_BR_RD1: begin
          if (ai < br_j) begin
            state_q <= S_BR_RD2;
          end else if (idx_q == IDX_NM1) begin
            idx_q   <= '0;
            lg_q    <= SW'(1);
            state_q <= S_BF_RD1;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_BR_RD2: begin
          tmp_q   <= rd_x;
          state_q <= S_BR_W1;
        end
        S_BR_W1: state_q <= S_BR_W2;
        S_BR_W2: begin
          idx_q   <= idx_q + 1'b1;
          state_q <= S_BR_RD1;
        end
        S_BF_RD1: state_q <= S_BF_RD2;
        S_BF_RD2: begin
          tmp_q   <= rd_x;
          state_q <= S_BF_MUL;
        end
        S_BF_MUL: state_q <= S_BF_WAIT;
        S_BF_WAIT: begin
          if (m0_done && m1_done) begin
            t_q     <= m0_p;
            g_q     <= m1_p;
            state_q <= S_BF_W2;
          end
        end
        S_BF_W2: begin
          if (idx_q == IDX_HM1) begin
            idx_q <= '0;
            if (lg_q == LG_LAST) begin
              case (pass_q)
                PASS_A: begin
                  pass_q  <= PASS_B;
                  state_q <= S_BR_RD1;
                end
                PASS_B: begin
                  pass_q  <= PASS_INV;
                  state_q <= S_PW_RD;
                end
                default: state_q <= S_EM_RD;
              endcase
            end else begin
              lg_q    <= lg_q + 1'b1;
              state_q <= S_BF_RD1;
            end
          end else begin
            idx_q   <= idx_q + 1'b1;
            state_q <= S_BF_RD1;
          end
        end
        S_PW_RD:  state_q <= S_PW_MUL;
        S_PW_MUL: state_q <= S_PW_WAIT;
        S_PW_WAIT: begin
          if (m0_done) begin
            if (idx_q == IDX_NM1) begin
              idx_q   <= '0;
              state_q <= S_BR_RD1;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_PW_RD;
            end
          end
        end
        S_EM_RD:  state_q <= S_EM_MUL;
        S_EM_MUL: state_q <= S_EM_WAIT;
        S_EM_WAIT: begin
          if (m0_done) begin
            res_q   <= m0_p;
            state_q <= S_EM_OUT;
          end
        end
        S_EM_OUT: begin
          if (slot_free) begin
            out_q       <= '{product_coefficient: res_q, last: (idx_q == size - IW'(1)),
                             dropped: ovf_q, empty_res: 1'b0};
            if (idx_q == size - IW'(1)) begin
              cnt_a_q <= '0;
              cnt_b_q <= '0;
              ovf_q   <= 1'b0;
              idx_q   <= '0;
              state_q <= S_IDLE;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_EM_RD;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

FILE: hw/rtl/ntt_polynomial_multiplier_top.sv
// ntt polynomial multiplier mod 998244353: loads are stored by the engine behind a
// two-entry command queue; a multiply clears the work memories, folds in both operands,
// then runs three n-point transforms on one butterfly unit with a bit-serial multiplier,
// with bit reversal swaps before each transform and a pointwise product between the
// second and third, then emits one result per product term, stalling while the output
// slot is full. asynchronous active-low reset empties the queues and the counts.
module ntt_polynomial_multiplier_top #(
  parameter int unsigned MAX_TERMS        = ntt_pkg::MAX_TERMS_DEF,
  parameter int unsigned TRANSFORM_POINTS = ntt_pkg::POINTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  input  ntt_pkg::in_item_t  in_item_i,
  output logic               full,
  output logic               empty,
  input  logic               pop,
  output ntt_pkg::out_item_t out_item_o
);
  import ntt_pkg::*;

  logic cmd_valid, cmd_ready, out_valid;
  cmd_t cmd;

  ntt_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .in_item_i   (in_item_i),
    .full_o      (full),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (cmd_ready)
  );

  ntt_engine #(
    .MAX_TERMS        (MAX_TERMS),
    .TRANSFORM_POINTS (TRANSFORM_POINTS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_ready_o (cmd_ready),
    .out_valid_o (out_valid),
    .out_item_o  (out_item_o),
    .pop_i       (pop)
  );

  assign empty = !out_valid;

  a_result_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> out_item_o.product_coefficient < COEF_W'(MODULUS))
    else $error("result not reduced");

  a_empty_is_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_item_o.empty_res) |->
      (out_item_o.last && out_item_o.product_coefficient == '0))
    else $error("empty result malformed");

  a_full_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> cmd_valid)
    else $error("queue full with no pending request");

endmodule
